FILE: hw/rtl/spq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_pkg: shared types and constants for the sorted min priority queue
// Holds the request and response records, command and status codes, and the
// default queue depth.
// ----------------------------------------------------------------------------
package spq_pkg;

   localparam int DEFAULT_CAPACITY = 64;
   localparam int VALUE_W          = 32;
   localparam int OCC_W            = 7;

   typedef logic signed [VALUE_W-1:0] value_type;

   localparam value_type UNDERFLOW_VALUE = -32'sd1;

   typedef enum logic {
      CMD_INSERT = 1'b0,
      CMD_REMOVE = 1'b1
   } command_type;

   typedef enum logic [1:0] {
      STATUS_OK        = 2'd0,
      STATUS_OVERFLOW  = 2'd1,
      STATUS_UNDERFLOW = 2'd2
   } status_type;

   typedef struct packed {
      command_type command;
      value_type   value;
   } req_type;

   typedef struct packed {
      value_type        out_value;
      status_type       status;
      logic [OCC_W-1:0] occupancy;
   } rsp_type;

   // chain-wide shift controls broadcast to every cell
   typedef struct packed {
      logic insert_en;
      logic remove_en;
   } shift_ctrl_type;

endpackage

FILE: hw/rtl/spq_cell.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Compares the broadcast request value with its own entry and takes the
// value from its lower neighbor, the request, or its upper neighbor.
// ----------------------------------------------------------------------------
module spq_cell import spq_pkg::*; #(
   parameter int CNT_W = 7,
   parameter int INDEX = 0
) (
   input  logic           clock,
   input  shift_ctrl_type ctrl,
   input  logic [CNT_W-1:0] count,
   input  value_type      req_value,
   input  value_type      prev_value,
   input  logic           prev_le,
   input  value_type      next_value,
   output value_type      cell_value,
   output logic           le
);

   value_type cell_value_ff;
   value_type cell_value_in;
   logic      occupied;

   // flag where the new value belongs: empty slot or stored value not smaller
   assign occupied = (count > CNT_W'(INDEX));
   assign le       = !occupied || (req_value <= cell_value_ff);

   // shift up behind the insert point, drop in at it, shift down on remove
   always_comb begin
      cell_value_in = cell_value_ff;
      if (ctrl.insert_en) begin
         if (prev_le) begin
            cell_value_in = prev_value;
         end else if (le) begin
            cell_value_in = req_value;
         end
      end else if (ctrl.remove_en) begin
         cell_value_in = next_value;
      end
   end

   always_ff @(posedge clock) begin
      cell_value_ff <= cell_value_in;
   end

   assign cell_value = cell_value_ff;

endmodule

FILE: hw/rtl/sorted_min_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sorted_min_priority_queue_top: min priority queue on a sorted cell chain
// Keeps up to CAPACITY signed values in ascending order, one per cell.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel: drive req_data (command, value) and raise start; the
//   request is taken on a rising edge where start is high and busy is low.
//   Command insert stores the value ahead of stored values that are not
//   smaller; command remove returns and drops the smallest value.
//   Response channel: rsp_valid strobes for one cycle with rsp_data
//   (out_value, status, occupancy) in the cycle after the request is taken.
//   The receiver cannot stall; each response must be captured on its strobe.
//   Throughput: one request per cycle. Every cell compares the request value
//   in parallel and moves its entry one slot on the same edge, so the whole
//   insert or remove completes on the edge that takes the request.
//   Insert into a full queue reports overflow and stores nothing; remove from
//   an empty queue returns -1 with underflow status.
//   Reset: synchronous, active high; empties the queue and holds busy high
//   while reset is asserted, clearing it on the first edge after release.
//   Cell contents are not cleared; only occupied cells are ever read.
// ----------------------------------------------------------------------------
module sorted_min_priority_queue_top import spq_pkg::*; #(
   parameter int CAPACITY = DEFAULT_CAPACITY
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_valid,
   output rsp_type rsp_data
);

   localparam int CNT_W = $clog2(CAPACITY + 1);

   logic [CNT_W-1:0] count_ff, count_in;
   logic             busy_ff, busy_in;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_type          rsp_data_ff, rsp_data_in;

   logic           accept;
   logic           full;
   logic           empty;
   shift_ctrl_type ctrl;

   value_type cell_values [CAPACITY];
   logic      cell_le     [CAPACITY];

   assign accept = start && !busy_ff;
   assign full   = (count_ff == CNT_W'(CAPACITY));
   assign empty  = (count_ff == '0);

   // gate chain shifts by occupancy
   always_comb begin
      ctrl.insert_en = accept && (req_data.command == CMD_INSERT) && !full;
      ctrl.remove_en = accept && (req_data.command == CMD_REMOVE) && !empty;
   end

   // build the chain of cells
   for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
      value_type prev_value;
      logic      prev_le;
      value_type next_value;

      if (i == 0) begin : g_head
         assign prev_value = cell_values[0];
         assign prev_le    = 1'b0;
      end else begin : g_body
         assign prev_value = cell_values[i-1];
         assign prev_le    = cell_le[i-1];
      end

      if (i == CAPACITY - 1) begin : g_tail
         assign next_value = cell_values[i];
      end else begin : g_inner
         assign next_value = cell_values[i+1];
      end

      spq_cell #(
         .CNT_W (CNT_W),
         .INDEX (i)
      ) u_cell (
         .clock      (clock),
         .ctrl       (ctrl),
         .count      (count_ff),
         .req_value  (req_data.value),
         .prev_value (prev_value),
         .prev_le    (prev_le),
         .next_value (next_value),
         .cell_value (cell_values[i]),
         .le         (cell_le[i])
      );
   end

   // advance count and build the response
   always_comb begin
      busy_in      = 1'b0;
      count_in     = count_ff;
      rsp_valid_in = accept;
      rsp_data_in  = rsp_data_ff;
      if (ctrl.insert_en) begin
         count_in = count_ff + CNT_W'(1);
      end else if (ctrl.remove_en) begin
         count_in = count_ff - CNT_W'(1);
      end
      if (accept) begin
         rsp_data_in.occupancy = OCC_W'(count_in);
         if (req_data.command == CMD_INSERT) begin
            rsp_data_in.out_value = '0;
            rsp_data_in.status    = full ? STATUS_OVERFLOW : STATUS_OK;
         end else if (empty) begin
            rsp_data_in.out_value = UNDERFLOW_VALUE;
            rsp_data_in.status    = STATUS_UNDERFLOW;
         end else begin
            rsp_data_in.out_value = cell_values[0];
            rsp_data_in.status    = STATUS_OK;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b1;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // hold response payload
   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign busy      = busy_ff;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

FILE: tb/tb_sorted_min_priority_queue_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_sorted_min_priority_queue_top: self-checking bench for the sorted queue
// Issues insert and remove requests, keeps its own sorted copy of the queue to
// predict each response, and checks every response strobe against the oldest
// prediction. Covers empty, full, duplicate and extreme-value cases, then runs
// fill, drain and mixed stretches with random sender gaps.
// ----------------------------------------------------------------------------
module tb_sorted_min_priority_queue_top import spq_pkg::*;;

   localparam int QUEUE_DEPTH    = DEFAULT_CAPACITY;
   localparam int NUM_SEGMENTS   = 20;
   localparam int SEG_LEN        = 100;
   localparam int QUIET_SEGMENTS = 3;
   localparam int WATCHDOG_LIMIT = 1000;
   localparam int SETTLE_CYCLES  = 4;

   // Sorted copy of the queue and the responses it predicts
   class pq_scoreboard;
      value_type stored_values[$];
      rsp_type   pending_rsp[$];
      int        depth;
      int        failures;

      function new(int queue_depth);
         depth    = queue_depth;
         failures = 0;
      endfunction

      function int pending();
         return pending_rsp.size();
      endfunction

      // Apply one accepted request and queue the response it should produce
      function void note_request(req_type r);
         rsp_type rsp;
         int      pos;
         rsp.out_value = '0;
         rsp.status    = STATUS_OK;
         if (r.command == CMD_INSERT) begin
            if (stored_values.size() >= depth) begin
               rsp.status = STATUS_OVERFLOW;
            end else begin
               // new value goes ahead of stored values that are not smaller
               pos = 0;
               while (pos < stored_values.size() && r.value > stored_values[pos])
                  pos++;
               stored_values.insert(pos, r.value);
            end
         end else if (stored_values.size() == 0) begin
            rsp.out_value = UNDERFLOW_VALUE;
            rsp.status    = STATUS_UNDERFLOW;
         end else begin
            rsp.out_value = stored_values.pop_front();
         end
         rsp.occupancy = OCC_W'(stored_values.size());
         pending_rsp.push_back(rsp);
      endfunction

      // Compare a response with the oldest prediction
      function void check_response(rsp_type got);
         rsp_type want;
         if (pending_rsp.size() == 0) begin
            $display("%0t: unexpected response out_value %0d status %0d occupancy %0d",
                     $time, got.out_value, got.status, got.occupancy);
            failures++;
            return;
         end
         want = pending_rsp.pop_front();
         if (got.out_value !== want.out_value) begin
            $display("%0t: out_value mismatch expected %0d actual %0d",
                     $time, want.out_value, got.out_value);
            failures++;
         end
         if (got.status !== want.status) begin
            $display("%0t: status mismatch expected %0d actual %0d",
                     $time, want.status, got.status);
            failures++;
         end
         if (got.occupancy !== want.occupancy) begin
            $display("%0t: occupancy mismatch expected %0d actual %0d",
                     $time, want.occupancy, got.occupancy);
            failures++;
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_data;
   logic    rsp_valid;
   rsp_type rsp_data;

   pq_scoreboard sb = new(QUEUE_DEPTH);
   int           idle_cycles;

   sorted_min_priority_queue_top #(
      .CAPACITY (QUEUE_DEPTH)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Record accepted requests and check responses
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid)
            sb.check_response(rsp_data);
         if (start && !busy)
            sb.note_request(req_data);
      end
   end

   // End the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (start && !busy) || rsp_valid)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Simulation FAILED");
         $finish;
      end
   end

   // Present one request and hold it until the block takes it
   task automatic send_request(input command_type cmd, input value_type val);
      req_type r;
      r.command = cmd;
      r.value   = val;
      req_data <= r;
      start    <= 1'b1;
      @(posedge clock);
      while (busy)
         @(posedge clock);
   endtask

   // Drop start for a number of cycles
   task automatic hold_off(input int cycles);
      start <= 1'b0;
      repeat (cycles) @(posedge clock);
   endtask

   // Drop start until every predicted response has arrived
   task automatic wait_drained();
      start <= 1'b0;
      do
         @(posedge clock);
      while (sb.pending() != 0);
   endtask

   // Mostly full-range values, with clusters of small ones for duplicates
   function automatic value_type pick_value();
      case ($urandom_range(0, 9))
         0:       return 32'sh7FFF_FFFF;
         1:       return 32'sh8000_0000;
         2, 3, 4: return value_type'($signed($urandom_range(0, 15)) - 8);
         default: return value_type'($urandom);
      endcase
   endfunction

   initial begin
      int          insert_pct;
      bit          idle_on;
      command_type cmd;

      reset    <= 1'b1;
      start    <= 1'b0;
      req_data <= '0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed: empty remove, extremes, duplicates, ignored value on remove
      send_request(CMD_REMOVE, 32'sh0000_0000);
      send_request(CMD_INSERT, 32'sh7FFF_FFFF);
      send_request(CMD_INSERT, 32'sh8000_0000);
      send_request(CMD_INSERT, 32'sh0000_0000);
      send_request(CMD_INSERT, -32'sd1);
      send_request(CMD_INSERT, 32'sh0000_0001);
      send_request(CMD_INSERT, -32'sd1);
      send_request(CMD_INSERT, 32'sh7FFF_FFFF);
      send_request(CMD_INSERT, 32'sh8000_0000);
      send_request(CMD_REMOVE, 32'sh5A5A_A5A5);
      send_request(CMD_REMOVE, -32'sd1);
      send_request(CMD_REMOVE, 32'sh0000_0000);
      send_request(CMD_REMOVE, 32'sh0000_0000);
      send_request(CMD_REMOVE, 32'sh0000_0000);
      send_request(CMD_REMOVE, 32'sh0000_0000);
      send_request(CMD_REMOVE, 32'sh0000_0000);
      send_request(CMD_REMOVE, 32'sh0000_0000);
      send_request(CMD_REMOVE, 32'sh0000_0000);
      send_request(CMD_INSERT, 32'sh1234_5678);
      send_request(CMD_REMOVE, 32'shFFFF_FFFF);

      // Random: fill, drain and mixed stretches; fill runs hit overflow
      for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
         case ((seg < 2) ? seg : $urandom_range(0, 2))
            0:       insert_pct = 90;
            1:       insert_pct = 12;
            default: insert_pct = 55;
         endcase
         idle_on = (seg < NUM_SEGMENTS - QUIET_SEGMENTS) && ($urandom_range(0, 3) != 0);
         if (seg < NUM_SEGMENTS - QUIET_SEGMENTS &&
             (seg == NUM_SEGMENTS / 2 || $urandom_range(0, 4) == 0))
            wait_drained();
         for (int i = 0; i < SEG_LEN; i++) begin
            if (idle_on && $urandom_range(0, 3) == 0)
               hold_off($urandom_range(1, 19));
            cmd = ($urandom_range(0, 99) < insert_pct) ? CMD_INSERT : CMD_REMOVE;
            send_request(cmd, pick_value());
         end
      end

      // Let the last responses arrive, then report
      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (sb.failures == 0 && sb.pending() == 0)
         $display("Simulation PASSED");
      else
         $display("Simulation FAILED");
      $finish;
   end

endmodule
